>>> rtl/smmd_pkg.sv
// Shared constants for the min/max zero-sequence SVPWM duty block.
package smmd_pkg;
  localparam int VOLT_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int PERIOD_RESET    = 4095;
  // sqrt(3)/2 in Q16
  localparam int HALF_SQRT3_Q16  = 56756;
  // stages ahead of the divider: input, phases, sum, ratio, product
  localparam int FRONT_STAGES    = 5;
endpackage

>>> rtl/smmd_if.sv
// Valid/ready channels for the voltage vector input and the duty result.
interface smmd_in_if #(
  parameter int VOLT_WIDTH = smmd_pkg::VOLT_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VOLT_WIDTH-1:0] volt_alpha;
  logic signed [VOLT_WIDTH-1:0] volt_beta;
  logic signed [VOLT_WIDTH-1:0] bus_volt;
  modport source (output valid, volt_alpha, volt_beta, bus_volt, input ready);
  modport sink (input valid, volt_alpha, volt_beta, bus_volt, output ready);
endinterface

interface smmd_out_if #(
  parameter int COUNT_WIDTH = smmd_pkg::COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] duty_a;
  logic [COUNT_WIDTH-1:0] duty_b;
  logic [COUNT_WIDTH-1:0] duty_c;
  modport source (output valid, duty_a, duty_b, duty_c, input ready);
  modport sink (input valid, duty_a, duty_b, duty_c, output ready);
endinterface

>>> rtl/smmd_div.sv
// Pipelined restoring divider: round-half-up of numerator / den, one quotient bit a stage.
module smmd_div #(
  parameter int COUNT_WIDTH = smmd_pkg::COUNT_WIDTH_DEF,
  parameter int DEN_WIDTH   = smmd_pkg::VOLT_WIDTH_DEF + 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [DEN_WIDTH+COUNT_WIDTH-1:0]     num_i,
  input  logic [DEN_WIDTH-1:0]                 den_i,
  output logic [COUNT_WIDTH-1:0]               quo_o
);
  localparam int PW = DEN_WIDTH + COUNT_WIDTH;

  logic [PW-1:0]          rem_r [COUNT_WIDTH];
  logic [DEN_WIDTH-1:0]   den_r [COUNT_WIDTH];
  logic [COUNT_WIDTH-1:0] quo_r [COUNT_WIDTH];
  logic [COUNT_WIDTH-1:0] quo_out_r;
  logic [COUNT_WIDTH-1:0] quo_out_nxt;

  for (genvar k = 0; k < COUNT_WIDTH; k++) begin : g_step
    localparam int B = COUNT_WIDTH - 1 - k;
    logic [PW-1:0]          rem_in;
    logic [DEN_WIDTH-1:0]   den_in;
    logic [COUNT_WIDTH-1:0] quo_in;
    logic [PW-1:0]          dsh;
    logic [PW-1:0]          rem_nxt;
    logic [COUNT_WIDTH-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      dsh     = PW'(den_in) << B;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= dsh) begin
        rem_nxt    = rem_in - dsh;
        quo_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  // remainder is below den here; round up when it reaches half
  assign quo_out_nxt = quo_r[COUNT_WIDTH-1] + COUNT_WIDTH'(
      {rem_r[COUNT_WIDTH-1], 1'b0} >= (PW+1)'(den_r[COUNT_WIDTH-1]));

  always_ff @(posedge clk) begin
    if (en) begin
      quo_out_r <= quo_out_nxt;
    end
  end

  assign quo_o = quo_out_r;
endmodule

>>> rtl/svpwm_minmax_duty.sv
// Top level: SVPWM compare counts by min/max zero-sequence injection.
//
// in_ch carries an alpha/beta voltage vector and the bus voltage, all in one
// signed scale. out_ch carries three compare counts, each 0..period, rounded
// half up from period * (0.5 + (Vx - offset) / vbus).
// cfg_we/cfg_wdata write the PWM period; write it only while the block is idle.
// A vector whose bus voltage is zero or negative gives no result.
//
// The pipeline holds five front stages (input, phase references, min/max
// sum, clamped ratio, period product), one divider stage per count bit and
// a rounding stage that is the output register. Throughput is one vector
// per cycle while the pipeline is not stalled; the long division is
// pipelined one quotient bit per stage.
// Reset empties the pipeline and loads a period of 4095. When a result waits
// on a receiver that holds off ready, the whole pipeline freezes and
// in_ch.ready drops; nothing is lost or repeated.
module svpwm_minmax_duty #(
  parameter int VOLT_WIDTH  = smmd_pkg::VOLT_WIDTH_DEF,
  parameter int COUNT_WIDTH = smmd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  smmd_in_if.sink                in_ch,
  smmd_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata
);
  import smmd_pkg::*;

  localparam int VW  = VOLT_WIDTH + 18;       // Q16 phase references
  localparam int SW  = VW + 1;                // max + min
  localparam int DW  = VW + 3;                // ratio numerator before clamp
  localparam int FW  = VOLT_WIDTH + 16;       // clamped numerator and full scale
  localparam int PW  = FW + COUNT_WIDTH;
  localparam int LAT = FRONT_STAGES + COUNT_WIDTH + 1;
  localparam logic signed [VW-1:0] KQ = VW'(HALF_SQRT3_Q16);

  logic [COUNT_WIDTH-1:0] period_r;
  logic [LAT-1:0]         vld_r;
  logic                   en;
  logic                   bus_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= COUNT_WIDTH'(PERIOD_RESET);
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign bus_pos     = !in_ch.bus_volt[VOLT_WIDTH-1] && (in_ch.bus_volt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid && bus_pos};
    end
  end

  // stage 1: register inputs, K * beta
  logic signed [VW-1:0]         kb_nxt, kb_r;
  logic signed [VOLT_WIDTH-1:0] alpha_r, vbus1_r;

  assign kb_nxt = VW'(in_ch.volt_beta) * KQ;

  always_ff @(posedge clk) begin
    if (en) begin
      kb_r    <= kb_nxt;
      alpha_r <= in_ch.volt_alpha;
      vbus1_r <= in_ch.bus_volt;
    end
  end

  // stage 2: phase references
  logic signed [VW-1:0]         ah;
  logic signed [VW-1:0]         v2_nxt [3];
  logic signed [VW-1:0]         v2_r [3];
  logic signed [VOLT_WIDTH-1:0] vbus2_r;

  always_comb begin
    ah        = VW'(alpha_r) <<< 15;
    v2_nxt[0] = VW'(alpha_r) <<< 16;
    v2_nxt[1] = kb_r - ah;
    v2_nxt[2] = -ah - kb_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r    <= v2_nxt;
      vbus2_r <= vbus1_r;
    end
  end

  // stage 3: max + min of the three
  logic signed [VW-1:0]         vmax, vmin;
  logic signed [SW-1:0]         sum_nxt, sum_r;
  logic signed [VW-1:0]         v3_r [3];
  logic signed [VOLT_WIDTH-1:0] vbus3_r;

  always_comb begin
    vmax = v2_r[0];
    vmin = v2_r[0];
    if (v2_r[1] > vmax) vmax = v2_r[1];
    if (v2_r[2] > vmax) vmax = v2_r[2];
    if (v2_r[1] < vmin) vmin = v2_r[1];
    if (v2_r[2] < vmin) vmin = v2_r[2];
    sum_nxt = SW'(vmax) + SW'(vmin);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_nxt;
      v3_r    <= v2_r;
      vbus3_r <= vbus2_r;
    end
  end

  // stage 4: Q17 ratio numerator, clamped to 0..full
  logic signed [DW-1:0] full_s;
  logic signed [DW-1:0] n_s [3];
  logic [FW-1:0]        num_nxt [3];
  logic [FW-1:0]        num_r [3];
  logic [FW-1:0]        full_nxt, full4_r;

  always_comb begin
    full_s   = DW'(vbus3_r) <<< 17;
    full_nxt = FW'(full_s);
    for (int i = 0; i < 3; i++) begin
      n_s[i] = (DW'(vbus3_r) <<< 16) + (DW'(v3_r[i]) <<< 1) - DW'(sum_r);
      if (n_s[i] < 0) begin
        num_nxt[i] = '0;
      end else if (n_s[i] > full_s) begin
        num_nxt[i] = full_nxt;
      end else begin
        num_nxt[i] = FW'(n_s[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num_nxt;
      full4_r <= full_nxt;
    end
  end

  // stage 5: scale by period
  logic [PW-1:0] prod_nxt [3];
  logic [PW-1:0] prod_r [3];
  logic [FW-1:0] full5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = PW'(num_r[i]) * PW'(period_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      full5_r <= full4_r;
    end
  end

  // divider pipelines, one per phase
  logic [COUNT_WIDTH-1:0] duty [3];

  for (genvar p = 0; p < 3; p++) begin : g_phase
    smmd_div #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .DEN_WIDTH   (FW)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (prod_r[p]),
      .den_i (full5_r),
      .quo_o (duty[p])
    );
  end

  assign out_ch.valid  = vld_r[LAT-1];
  assign out_ch.duty_a = duty[0];
  assign out_ch.duty_b = duty[1];
  assign out_ch.duty_c = duty[2];

  a_duty_a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_a <= period_r)
    else $error("duty_a above period");
  a_duty_b_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_b <= period_r)
    else $error("duty_b above period");
  a_duty_c_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_c <= period_r)
    else $error("duty_c above period");
  a_bus_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !bus_pos) |=> !vld_r[0])
    else $error("vector with nonpositive bus entered pipeline");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");
endmodule
